// ----- rtl/tba_pkg.sv -----
// Shared types and constants for the time bucket aggregator.
package tba_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int OFFSET_W  = 32;
   localparam int LEN_W     = 40;
   localparam int BASE_W    = 62;
   localparam int TIME_W    = 63;
   localparam int TOTAL_W   = 64;
   localparam int COUNT_W   = 32;
   localparam int QTOT_W    = 40;
   localparam int QUAL_W    = 8;
   localparam int MS_W      = 10;
   localparam int PROD_W    = OFFSET_W + MS_W;
   localparam logic [MS_W-1:0] MS_TO_US = MS_W'(1000);

   // divider geometry: widest dividend is the 64-bit value total
   localparam int DIVIDEND_W = TOTAL_W;
   localparam int DIVISOR_W  = LEN_W;

   // register map
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_BUCKET_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BATCH_BASE    = 1'b1;

   localparam logic [LEN_W-1:0] BUCKET_LENGTH_RESET = LEN_W'(1000000);

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL,
      S_ADD,
      S_ALIGN_GO,
      S_ALIGN_WAIT,
      S_UPDATE,
      S_MEAN_GO,
      S_MEAN_WAIT,
      S_QUAL_GO,
      S_QUAL_WAIT,
      S_SEND,
      S_FLUSH_CHECK
   } state_type;

endpackage

// ----- rtl/tba_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
module tba_div #(
   parameter int DIVIDEND_W = tba_pkg::DIVIDEND_W,
   parameter int DIVISOR_W  = tba_pkg::DIVISOR_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  busy,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic [DIVISOR_W-1:0]  remainder
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W-1:0]  dvs_ff;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    diff;

   // trial subtract of the divisor from the shifted partial remainder
   assign shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + 1'b1;
            if (count_ff == CNT_W'(DIVIDEND_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         if (!diff[DIVISOR_W]) begin
            rem_ff <= diff[DIVISOR_W-1:0];
            quo_ff <= {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_ff <= shifted[DIVISOR_W-1:0];
            quo_ff <= {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
      end
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ----- rtl/time_bucket_aggregator.sv -----
// Top level of the time bucket aggregator: sequencer, bucket state, output register.
//
// Usage:
//  req_ carries one sample per word: offset in ms, Q16.16 value and quality
//  in tdata, the batch-end mark in tlast. rsp_ carries bucket summaries: start,
//  count, first, last, mean, min, max, quality in tdata; tuser is 1 for the
//  zero-length error result; tlast marks the last result of one input word.
//  csr_ writes bucket_length_us (index 0) and batch_base_us (index 1); write
//  only while the block is idle.
// Timing: every sample passes one multiply, one add and an alignment division
//  in the divider, and req_tready is low until the word is finished. Each
//  emitted bucket adds two more divider passes (mean, quality) plus the send
//  step before the next word is taken. With zero length a word skips the
//  division, and a word that ends the batch also takes the send step for the error.
// Reset: synchronous; no bucket open, length 1000000 us, base 0.
// Stall: a result waits in the output register; a new sample is accepted
//  meanwhile, and a second result waits until the first is taken.
module time_bucket_aggregator #(
   parameter int VALUE_WIDTH = tba_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   // offset_ms, sample_value, sample_quality
   input  logic [((tba_pkg::OFFSET_W + VALUE_WIDTH + tba_pkg::QUAL_W + 7) / 8) * 8 - 1:0]
                req_tdata,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic req_tlast,
   // bucket_start_us, bucket_count, opening_value, closing_value, mean_value,
   // lowest_value, highest_value, bucket_quality
   output logic [((tba_pkg::TIME_W + tba_pkg::COUNT_W + 5 * VALUE_WIDTH
                   + tba_pkg::QUAL_W + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic rsp_tlast,
   // status
   output logic rsp_tuser,
   input  logic                           csr_we,
   input  logic [tba_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tba_pkg::BASE_W-1:0]     csr_wdata
);

   localparam int VW       = VALUE_WIDTH;
   localparam int RSP_BITS = tba_pkg::TIME_W + tba_pkg::COUNT_W + 5 * VW + tba_pkg::QUAL_W;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;
   localparam int OFF_LO   = 0;
   localparam int VAL_LO   = tba_pkg::OFFSET_W;
   localparam int QUA_LO   = tba_pkg::OFFSET_W + VW;

   tba_pkg::state_type state_ff, state_in;

   // configuration
   logic [tba_pkg::LEN_W-1:0]  len_ff;
   logic [tba_pkg::BASE_W-1:0] base_ff;

   // current word
   logic [tba_pkg::OFFSET_W-1:0] off_ff;
   logic signed [VW-1:0]         val_ff;
   logic [tba_pkg::QUAL_W-1:0]   qual_ff;
   logic                         end_ff;
   logic [tba_pkg::PROD_W-1:0]   prod_ff;
   logic [tba_pkg::TIME_W-1:0]   t_ff;
   logic                         err_ff;
   logic                         flush_ff;
   logic signed [VW-1:0]         mean_ff;

   // open bucket
   logic                         open_ff;
   logic [tba_pkg::TIME_W-1:0]   obs_ff;
   logic [tba_pkg::COUNT_W-1:0]  tally_ff;
   logic [tba_pkg::TOTAL_W-1:0]  vtot_ff;
   logic [tba_pkg::QTOT_W-1:0]   qtot_ff;
   logic signed [VW-1:0]         low_ff;
   logic signed [VW-1:0]         high_ff;
   logic signed [VW-1:0]         first_ff;
   logic signed [VW-1:0]         last_ff;

   // output register
   logic                rsp_valid_ff;
   logic                rsp_last_ff;
   logic                rsp_err_ff;
   logic [RSP_BITS-1:0] rsp_bits_ff;

   // divider hookup
   logic                              div_start;
   logic [tba_pkg::DIVIDEND_W-1:0]    div_dividend;
   logic [tba_pkg::DIVISOR_W-1:0]     div_divisor;
   logic                              div_busy;
   logic                              div_done;
   logic [tba_pkg::DIVIDEND_W-1:0]    div_quo;
   logic [tba_pkg::DIVISOR_W-1:0]     div_rem;

   logic                              in_accept;
   logic                              send_ok;
   logic                              len_zero;
   logic [tba_pkg::COUNT_W-1:0]       cnt;
   logic                              neg;
   logic [tba_pkg::TOTAL_W-1:0]       mag;
   logic [tba_pkg::TIME_W-1:0]        aligned;
   logic [tba_pkg::TIME_W:0]          obs_end;
   logic                              past_end;
   logic                              before_open;

   assign in_accept   = req_tvalid && req_tready;
   assign send_ok     = !rsp_valid_ff || rsp_tready;
   assign len_zero    = (len_ff == '0);
   assign cnt         = (tally_ff == '0) ? tba_pkg::COUNT_W'(1) : tally_ff;
   assign neg         = vtot_ff[tba_pkg::TOTAL_W-1];
   assign mag         = neg ? (~vtot_ff + 1'b1) : vtot_ff;
   assign aligned     = t_ff - tba_pkg::TIME_W'(div_rem);
   assign obs_end     = {1'b0, obs_ff} + (tba_pkg::TIME_W + 1)'(len_ff);
   assign past_end    = {1'b0, t_ff} >= obs_end;
   assign before_open = t_ff < obs_ff;

   // one divider serves alignment, mean and quality
   always_comb begin
      case (state_ff)
         tba_pkg::S_ALIGN_GO: begin
            div_dividend = tba_pkg::DIVIDEND_W'(t_ff);
            div_divisor  = len_ff;
         end
         tba_pkg::S_MEAN_GO: begin
            div_dividend = mag;
            div_divisor  = tba_pkg::DIVISOR_W'(cnt);
         end
         default: begin
            div_dividend = tba_pkg::DIVIDEND_W'(qtot_ff);
            div_divisor  = tba_pkg::DIVISOR_W'(cnt);
         end
      endcase
   end

   tba_div #(
      .DIVIDEND_W(tba_pkg::DIVIDEND_W),
      .DIVISOR_W (tba_pkg::DIVISOR_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo),
      .remainder(div_rem)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tba_pkg::S_IDLE:       if (in_accept) state_in = tba_pkg::S_MUL;
         tba_pkg::S_MUL:        state_in = tba_pkg::S_ADD;
         tba_pkg::S_ADD: begin
            if (!len_zero)   state_in = tba_pkg::S_ALIGN_GO;
            else if (end_ff) state_in = tba_pkg::S_SEND;
            else             state_in = tba_pkg::S_IDLE;
         end
         tba_pkg::S_ALIGN_GO:   state_in = tba_pkg::S_ALIGN_WAIT;
         tba_pkg::S_ALIGN_WAIT: if (div_done) state_in = tba_pkg::S_UPDATE;
         tba_pkg::S_UPDATE: begin
            if (open_ff && past_end) state_in = tba_pkg::S_MEAN_GO;
            else                     state_in = tba_pkg::S_FLUSH_CHECK;
         end
         tba_pkg::S_MEAN_GO:    state_in = tba_pkg::S_MEAN_WAIT;
         tba_pkg::S_MEAN_WAIT:  if (div_done) state_in = tba_pkg::S_QUAL_GO;
         tba_pkg::S_QUAL_GO:    state_in = tba_pkg::S_QUAL_WAIT;
         tba_pkg::S_QUAL_WAIT:  if (div_done) state_in = tba_pkg::S_SEND;
         tba_pkg::S_SEND: begin
            if (send_ok) begin
               if (err_ff || flush_ff) state_in = tba_pkg::S_IDLE;
               else                    state_in = tba_pkg::S_FLUSH_CHECK;
            end
         end
         tba_pkg::S_FLUSH_CHECK: begin
            if (end_ff && open_ff) state_in = tba_pkg::S_MEAN_GO;
            else                   state_in = tba_pkg::S_IDLE;
         end
         default:               state_in = tba_pkg::S_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = (state_ff == tba_pkg::S_IDLE);
      div_start  = (state_ff == tba_pkg::S_ALIGN_GO) || (state_ff == tba_pkg::S_MEAN_GO)
                   || (state_ff == tba_pkg::S_QUAL_GO);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tba_pkg::S_IDLE;
         len_ff       <= tba_pkg::BUCKET_LENGTH_RESET;
         base_ff      <= '0;
         open_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               tba_pkg::CSR_BUCKET_LENGTH: len_ff  <= csr_wdata[tba_pkg::LEN_W-1:0];
               tba_pkg::CSR_BATCH_BASE:    base_ff <= csr_wdata;
               default: ;
            endcase
         end
         // a new result replaces the one being taken
         if ((state_ff == tba_pkg::S_SEND) && send_ok) rsp_valid_ff <= 1'b1;
         else if (rsp_tready)                           rsp_valid_ff <= 1'b0;
         case (state_ff)
            tba_pkg::S_UPDATE:
               if (!open_ff) open_ff <= 1'b1;
            tba_pkg::S_SEND: begin
               if (send_ok) open_ff <= !(err_ff || flush_ff);
            end
            default: ;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         tba_pkg::S_IDLE: begin
            if (in_accept) begin
               off_ff   <= req_tdata[OFF_LO +: tba_pkg::OFFSET_W];
               val_ff   <= req_tdata[VAL_LO +: VW];
               qual_ff  <= req_tdata[QUA_LO +: tba_pkg::QUAL_W];
               end_ff   <= req_tlast;
               flush_ff <= 1'b0;
            end
         end
         tba_pkg::S_MUL: prod_ff <= off_ff * tba_pkg::MS_TO_US;
         tba_pkg::S_ADD: begin
            t_ff   <= tba_pkg::TIME_W'(base_ff) + tba_pkg::TIME_W'(prod_ff);
            err_ff <= len_zero;
         end
         tba_pkg::S_UPDATE: begin
            if (!open_ff) begin
               obs_ff   <= aligned;
               tally_ff <= tba_pkg::COUNT_W'(1);
               vtot_ff  <= tba_pkg::TOTAL_W'(val_ff);
               qtot_ff  <= tba_pkg::QTOT_W'(qual_ff);
               low_ff   <= val_ff;
               high_ff  <= val_ff;
               first_ff <= val_ff;
               last_ff  <= val_ff;
            end else if (past_end) begin
               // keep the new bucket start until the closed one is sent
               t_ff <= aligned;
            end else if (!before_open) begin
               if (tally_ff != {tba_pkg::COUNT_W{1'b1}}) begin
                  tally_ff <= tally_ff + 1'b1;
                  vtot_ff  <= vtot_ff + tba_pkg::TOTAL_W'(val_ff);
                  qtot_ff  <= qtot_ff + tba_pkg::QTOT_W'(qual_ff);
               end
               if (val_ff < low_ff)  low_ff  <= val_ff;
               if (val_ff > high_ff) high_ff <= val_ff;
               last_ff <= val_ff;
            end
         end
         tba_pkg::S_FLUSH_CHECK:
            if (end_ff && open_ff) flush_ff <= 1'b1;
         tba_pkg::S_QUAL_GO: begin
            // mean quotient is ready here
            mean_ff <= neg ? -div_quo[VW-1:0] : div_quo[VW-1:0];
         end
         tba_pkg::S_SEND: begin
            if (send_ok) begin
               rsp_err_ff  <= err_ff;
               rsp_last_ff <= err_ff || flush_ff || !end_ff;
               if (err_ff)
                  rsp_bits_ff <= '0;
               else
                  rsp_bits_ff <= {div_quo[tba_pkg::QUAL_W-1:0], high_ff, low_ff, mean_ff,
                                  last_ff, first_ff, tally_ff, obs_ff};
               // closing a bucket on a later sample opens the next one
               if (!err_ff && !flush_ff) begin
                  obs_ff   <= t_ff;
                  tally_ff <= tba_pkg::COUNT_W'(1);
                  vtot_ff  <= tba_pkg::TOTAL_W'(val_ff);
                  qtot_ff  <= tba_pkg::QTOT_W'(qual_ff);
                  low_ff   <= val_ff;
                  high_ff  <= val_ff;
                  first_ff <= val_ff;
                  last_ff  <= val_ff;
               end
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_err_ff;
   assign rsp_tdata  = RSP_W'(rsp_bits_ff);

   // divider is never running while a new word can be taken
   a_idle_div: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_busy) else $error("divider busy while idle");

   // an error result is always the last of its word
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast) else $error("error result not last");

   // an open bucket always holds at least one sample
   a_open_count: assert property (@(posedge clock) disable iff (reset)
      open_ff |-> (tally_ff != '0)) else $error("open bucket with zero count");

   // a result only appears from the send step
   a_send_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == tba_pkg::S_SEND))
      else $error("result loaded outside send");

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the time bucket aggregator: stream stimulus, bucket predictor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VW    = 32;
   localparam int REQ_W = ((tba_pkg::OFFSET_W + VW + tba_pkg::QUAL_W + 7) / 8) * 8;
   localparam int RSP_W = ((tba_pkg::TIME_W + tba_pkg::COUNT_W + 5 * VW
                            + tba_pkg::QUAL_W + 7) / 8) * 8;
   localparam int DRAIN_CYCLES = 400;
   localparam int STALL_LIMIT  = 20000;

   typedef struct packed {
      logic [tba_pkg::TIME_W-1:0]  start_us;
      logic [tba_pkg::COUNT_W-1:0] count;
      logic [VW-1:0]               first_v;
      logic [VW-1:0]               last_v;
      logic [VW-1:0]               mean_v;
      logic [VW-1:0]               low_v;
      logic [VW-1:0]               high_v;
      logic [tba_pkg::QUAL_W-1:0]  quality;
      logic                        status;
      logic                        last;
   } bucket_summary_type;

   // Bucket predictor plus the queue of summaries still owed by the block
   class bucket_scoreboard;
      logic [tba_pkg::LEN_W-1:0]   len_us;
      logic [tba_pkg::BASE_W-1:0]  base_us;
      bit                          is_open;
      logic [63:0]                 open_start;
      logic [tba_pkg::COUNT_W-1:0] tally;
      logic [63:0]                 v_total;
      logic [63:0]                 q_total;
      logic [63:0]                 lo, hi, first_s, last_s;
      bucket_summary_type          owed[$];
      int unsigned                 mismatches;
      int unsigned                 buckets_seen;
      int unsigned                 errors_seen;

      function new();
         len_us = tba_pkg::BUCKET_LENGTH_RESET;
         base_us = '0;
         mismatches = 0;
         buckets_seen = 0;
         errors_seen = 0;
         clear();
      endfunction

      function void clear();
         is_open = 0; open_start = 0; tally = 0; v_total = 0; q_total = 0;
         lo = 0; hi = 0; first_s = 0; last_s = 0;
      endfunction

      function void open_with(logic [63:0] start, logic [63:0] v, logic [63:0] q);
         is_open = 1; open_start = start; tally = 1; v_total = v; q_total = q;
         lo = v; hi = v; first_s = v; last_s = v;
      endfunction

      function bucket_summary_type summary();
         bucket_summary_type s;
         logic [63:0] cnt, mag, quo;
         bit neg;
         cnt = (tally != 0) ? 64'(tally) : 64'd1;
         neg = v_total[63];
         mag = neg ? -v_total : v_total;
         quo = mag / cnt;
         s.start_us = open_start[tba_pkg::TIME_W-1:0];
         s.count    = tally;
         s.first_v  = first_s[VW-1:0];
         s.last_v   = last_s[VW-1:0];
         s.mean_v   = neg ? VW'(-quo) : VW'(quo);
         s.low_v    = lo[VW-1:0];
         s.high_v   = hi[VW-1:0];
         s.quality  = tba_pkg::QUAL_W'(q_total / cnt);
         s.status   = 0;
         s.last     = 0;
         return s;
      endfunction

      function void write_reg(logic [tba_pkg::CSR_IDX_W-1:0] idx,
                              logic [tba_pkg::BASE_W-1:0] d);
         if (idx == tba_pkg::CSR_BUCKET_LENGTH) len_us = d[tba_pkg::LEN_W-1:0];
         else base_us = d;
      endfunction

      // Work out what one accepted sample word causes
      function void note_input(logic [31:0] off, logic [VW-1:0] val, logic [7:0] q, bit fin);
         logic [63:0] t, start, v, qq;
         bucket_summary_type s, made[$];
         v = {{(64-VW){val[VW-1]}}, val};
         qq = 64'(q);
         if (len_us == 0) begin
            if (fin) begin
               clear();
               s = '0;
               s.status = 1;
               s.last = 1;
               owed.insert(owed.size(), s);
            end
            return;
         end
         t = 64'(base_us) + 64'(off) * 64'd1000;
         start = t - (t % 64'(len_us));
         if (!is_open) begin
            open_with(start, v, qq);
         end else if (t >= open_start + 64'(len_us)) begin
            made.insert(made.size(), summary());
            open_with(start, v, qq);
         end else if (t >= open_start) begin
            if (tally != '1) begin
               tally++;
               v_total += v;
               q_total += qq;
            end
            if ($signed(v) < $signed(lo)) lo = v;
            if ($signed(hi) < $signed(v)) hi = v;
            last_s = v;
         end
         // earlier than the open bucket: dropped
         if (fin && is_open) begin
            made.insert(made.size(), summary());
            clear();
         end
         if (made.size() > 0) made[made.size()-1].last = 1;
         foreach (made[i]) owed.insert(owed.size(), made[i]);
      endfunction

      // Compare one accepted result word with the oldest owed summary
      function void check(logic [RSP_W-1:0] data, bit lst, bit usr);
         bucket_summary_type got, want;
         got.start_us = data[62:0];
         got.count    = data[94:63];
         got.first_v  = data[126:95];
         got.last_v   = data[158:127];
         got.mean_v   = data[190:159];
         got.low_v    = data[222:191];
         got.high_v   = data[254:223];
         got.quality  = data[262:255];
         got.status   = usr;
         got.last     = lst;
         if (usr) errors_seen++; else buckets_seen++;
         if (owed.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word: %p", got);
            return;
         end
         want = owed.pop_front();
         if (got != want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("result mismatch");
               $display("  expected %p", want);
               $display("  actual   %p", got);
            end
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic [REQ_W-1:0] req_tdata = '0;
   logic req_tvalid = 0, req_tlast = 0;
   logic req_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic rsp_tvalid, rsp_tlast, rsp_tuser;
   logic rsp_tready = 0;
   logic csr_we = 0;
   logic [tba_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [tba_pkg::BASE_W-1:0] csr_wdata = '0;

   bucket_scoreboard sb = new();
   bit quiet = 0;           // no idling on either side while set
   int unsigned words_in = 0;
   int unsigned stall_cycles = 0;

   always #5 clock = ~clock;

   time_bucket_aggregator #(.VALUE_WIDTH(VW)) dut (.*);

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog expired after %0d idle cycles", stall_cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

   // Result side: random stalls, check each accepted word
   initial begin
      int unsigned gap;
      @(negedge reset);
      forever begin
         gap = quiet ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            rsp_tready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check(rsp_tdata, rsp_tlast, rsp_tuser);
      end
   end

   task automatic send_word(logic [31:0] off, logic [VW-1:0] val, logic [7:0] q, bit fin);
      int unsigned gap;
      gap = quiet ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= REQ_W'({q, val, off});
      req_tlast  <= fin;
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      sb.note_input(off, val, q, fin);
      words_in++;
   endtask

   task automatic write_csr(logic [tba_pkg::CSR_IDX_W-1:0] idx, logic [tba_pkg::BASE_W-1:0] d);
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      csr_we <= 0;
      @(posedge clock);
      sb.write_reg(idx, d);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [VW-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return {1'b1, {(VW-1){1'b0}}};
         1: return {1'b0, {(VW-1){1'b1}}};
         2: return VW'($urandom_range(0, 200)) - VW'(100);
         default: return VW'($urandom);
      endcase
   endfunction

   // Random bucket traffic: mostly ascending times, some stray offsets
   task automatic random_phase(int unsigned n);
      logic [31:0] cur, off;
      int unsigned span;
      cur = $urandom_range(0, 1000);
      span = (sb.len_us / 1000 > 40'd100000) ? 100000 : int'(sb.len_us / 1000) + 2;
      for (int unsigned i = 0; i < n; i++) begin
         if (i == n / 2) begin
            // hold off until the block has caught up
            req_tvalid <= 0;
            @(posedge clock);
            while (sb.owed.size() != 0) @(posedge clock);
         end
         quiet = (i % 200) >= 170;
         if ($urandom_range(0, 9) == 0) begin
            off = $urandom;
         end else begin
            cur = cur + $urandom_range(0, span);
            off = cur;
         end
         send_word(off, pick_value(), 8'($urandom_range(0, 255)), $urandom_range(0, 11) == 0);
      end
      quiet = 0;
   endtask

   initial begin
      logic [tba_pkg::BASE_W-1:0] rb;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: reset config, field extremes, drops, flushes
      send_word(32'd0, {1'b1, {(VW-1){1'b0}}}, 8'd0, 1'b0);
      send_word(32'd1, {1'b0, {(VW-1){1'b1}}}, 8'd255, 1'b0);
      send_word(32'd999, VW'(-1), 8'd1, 1'b0);
      send_word(32'd1000, VW'(0), 8'd128, 1'b0);
      send_word(32'd500, VW'(7), 8'd9, 1'b0);          // before open bucket
      send_word(32'd1001, VW'(-3), 8'd200, 1'b1);      // flush
      send_word(32'd5000, VW'(5), 8'd3, 1'b1);         // open and flush together
      send_word(32'd6000, VW'(11), 8'd4, 1'b0);
      send_word(32'd9000, VW'(12), 8'd5, 1'b1);        // close plus flush
      send_word(32'hFFFF_FFFF, {VW{1'b1}}, 8'hFF, 1'b0);
      send_word(32'hFFFF_FFFF, VW'(2), 8'h0F, 1'b1);
      drain();
      write_csr(tba_pkg::CSR_BUCKET_LENGTH, tba_pkg::BASE_W'(0));   // zero length error
      send_word(32'd10, VW'(1), 8'd1, 1'b0);
      send_word(32'd20, VW'(2), 8'd2, 1'b1);
      send_word(32'd30, VW'(3), 8'd3, 1'b1);
      drain();
      write_csr(tba_pkg::CSR_BUCKET_LENGTH, tba_pkg::BASE_W'(1));
      write_csr(tba_pkg::CSR_BATCH_BASE, {tba_pkg::BASE_W{1'b1}});
      send_word(32'd0, VW'(4), 8'd4, 1'b0);
      send_word(32'd0, VW'(5), 8'd5, 1'b0);
      send_word(32'd1, VW'(6), 8'd6, 1'b1);
      send_word(32'd0, VW'(7), 8'd7, 1'b1);            // batch end, nothing open before
      drain();

      // Random phases across settings
      random_phase(300);
      drain();
      write_csr(tba_pkg::CSR_BUCKET_LENGTH, tba_pkg::BASE_W'(5000));
      write_csr(tba_pkg::CSR_BATCH_BASE, tba_pkg::BASE_W'(0));
      random_phase(300);
      drain();
      write_csr(tba_pkg::CSR_BUCKET_LENGTH, tba_pkg::BASE_W'(0));
      random_phase(150);
      drain();
      write_csr(tba_pkg::CSR_BUCKET_LENGTH,
                {{(tba_pkg::BASE_W-tba_pkg::LEN_W){1'b0}}, {tba_pkg::LEN_W{1'b1}}});
      write_csr(tba_pkg::CSR_BATCH_BASE, {tba_pkg::BASE_W{1'b1}});
      random_phase(250);
      drain();
      rb = tba_pkg::BASE_W'({$urandom, $urandom});
      write_csr(tba_pkg::CSR_BUCKET_LENGTH, tba_pkg::BASE_W'(37000));
      write_csr(tba_pkg::CSR_BATCH_BASE, rb);
      random_phase(300);
      drain();
      rb = tba_pkg::BASE_W'({$urandom, $urandom});
      write_csr(tba_pkg::CSR_BUCKET_LENGTH, tba_pkg::BASE_W'($urandom_range(1000, 3000000)));
      write_csr(tba_pkg::CSR_BATCH_BASE, rb);
      random_phase(480);
      drain();

      $display("%0d sample words sent, %0d bucket summaries and %0d error results checked",
               words_in, sb.buckets_seen, sb.errors_seen);
      $display("settings covered zero, one, mid and maximum bucket lengths, zero to max base");
      if (sb.mismatches == 0 && sb.owed.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.mismatches, sb.owed.size());
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
